// File: rtl/ast_pkg.sv
// ============================================================================
// ast_pkg
// Shared types and constants of the angular sector test pipeline.
// ============================================================================
`default_nettype none

package ast_pkg;

    localparam int FACE_W      = 16;
    localparam int DEG_IN_W    = 11;
    localparam int DEG_W       = 10;
    localparam int ANGLE_OUT_W = 17;
    localparam int ZFRAC       = 16;
    localparam int ZW          = 26;
    localparam int ATAN_W      = 22;
    localparam int MAX_STEPS   = 24;

    localparam logic signed [ZW-1:0] Z_0   = 26'sd0;
    localparam logic signed [ZW-1:0] Z_90  = 26'sd5898240;
    localparam logic signed [ZW-1:0] Z_180 = 26'sd11796480;
    localparam logic signed [ZW-1:0] Z_270 = 26'sd17694720;
    localparam logic signed [ZW-1:0] Z_360 = 26'sd23592960;

    typedef logic [ATAN_W-1:0] atan_t;

    // atan(2^-i) in degrees, 16 fraction bits
    localparam atan_t ATAN_TAB [MAX_STEPS] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    typedef struct packed {
        logic signed [DEG_W-1:0] lo;
        logic signed [DEG_W-1:0] hi;
        logic                    z_fixed;
    } side_t;

endpackage

`default_nettype wire

// File: rtl/ast_if.sv
// ============================================================================
// ast_if
// Word channels of the angular sector test: probe in, verdict out.
// ============================================================================
`default_nettype none

interface ast_in_if import ast_pkg::*; #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic signed [FACE_W-1:0]     face_x;
    logic signed [FACE_W-1:0]     face_y;
    logic signed [COORD_BITS-1:0] own_x;
    logic signed [COORD_BITS-1:0] own_y;
    logic signed [COORD_BITS-1:0] tgt_x;
    logic signed [COORD_BITS-1:0] tgt_y;
    logic signed [DEG_IN_W-1:0]   min_deg;
    logic signed [DEG_IN_W-1:0]   max_deg;

    modport source (
        output valid, face_x, face_y, own_x, own_y, tgt_x, tgt_y, min_deg, max_deg,
        input  ready
    );
    modport sink (
        input  valid, face_x, face_y, own_x, own_y, tgt_x, tgt_y, min_deg, max_deg,
        output ready
    );
endinterface

interface ast_out_if import ast_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic                   in_sector;
    logic [ANGLE_OUT_W-1:0] angle_fx;

    modport source (
        output valid, in_sector, angle_fx,
        input  ready
    );
    modport sink (
        input  valid, in_sector, angle_fx,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/ast_front.sv
// ============================================================================
// ast_front
// Front stages: offsets, products, dot and cross, quadrant fold and axis cases.
// ============================================================================
`default_nettype none

module ast_front import ast_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    ast_in_if.sink                            probe,
    output logic                              dn_valid,
    input  wire logic                         dn_ready,
    output logic signed [COORD_BITS+18:0]     dn_x,
    output logic signed [COORD_BITS+18:0]     dn_y,
    output logic signed [ZW-1:0]              dn_z,
    output side_t                             dn_side
);

    localparam int DW        = COORD_BITS + 1;
    localparam int PW        = COORD_BITS + 17;
    localparam int CW        = COORD_BITS + 19;
    localparam int DEG_SUM_W = DEG_IN_W + 1;

    localparam logic signed [DEG_SUM_W-1:0] R360  = DEG_SUM_W'(360);
    localparam logic signed [DEG_SUM_W-1:0] R720  = DEG_SUM_W'(720);
    localparam logic signed [DEG_SUM_W-1:0] R1080 = DEG_SUM_W'(1080);

    function automatic logic signed [DEG_W-1:0] reduce_deg(
        input logic signed [DEG_IN_W-1:0] d
    );
        logic signed [DEG_SUM_W-1:0] v;
        logic signed [DEG_SUM_W-1:0] r;
        v = DEG_SUM_W'(d) + R360;
        if (v < 0)
        begin
            r = (v <= -R360) ? v + R360 : v;
        end
        else if (v >= R1080)
        begin
            r = v - R1080;
        end
        else if (v >= R720)
        begin
            r = v - R720;
        end
        else if (v >= R360)
        begin
            r = v - R360;
        end
        else
        begin
            r = v;
        end
        return DEG_W'(r);
    endfunction

    logic                     v0_reg, v1_reg, v2_reg, v3_reg;
    logic                     v0_next, v1_next, v2_next, v3_next;
    logic                     rdy0, rdy1, rdy2, rdy3;

    logic signed [FACE_W-1:0] fx_reg, fy_reg;
    logic signed [DW-1:0]     dx_reg, dy_reg, dx_next, dy_next;
    side_t                    side0_reg, side1_reg, side2_reg, side3_reg, side0_next;

    logic signed [PW-1:0]     pxx_reg, pyy_reg, pxy_reg, pyx_reg;
    logic signed [PW-1:0]     pxx_next, pyy_next, pxy_next, pyx_next;

    logic signed [PW-1:0]     dot_reg, crs_reg, dot_next, crs_next;

    logic signed [CW-1:0]     x_reg, y_reg, x_next, y_next, x_ext, y_ext;
    logic signed [ZW-1:0]     z_reg, z_next;
    logic                     fixed_next;

    assign rdy3        = !v3_reg || dn_ready;
    assign rdy2        = !v2_reg || rdy3;
    assign rdy1        = !v1_reg || rdy2;
    assign rdy0        = !v0_reg || rdy1;
    assign probe.ready = rdy0;

    assign v0_next = rdy0 ? probe.valid : v0_reg;
    assign v1_next = rdy1 ? v0_reg : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;

    assign dx_next    = DW'(probe.tgt_x) - DW'(probe.own_x);
    assign dy_next    = DW'(probe.tgt_y) - DW'(probe.own_y);
    assign side0_next = '{lo: reduce_deg(probe.min_deg),
                          hi: reduce_deg(probe.max_deg),
                          z_fixed: 1'b0};

    assign pxx_next = PW'(fx_reg) * PW'(dx_reg);
    assign pyy_next = PW'(fy_reg) * PW'(dy_reg);
    assign pxy_next = PW'(fx_reg) * PW'(dy_reg);
    assign pyx_next = PW'(fy_reg) * PW'(dx_reg);

    assign dot_next = pxx_reg + pyy_reg;
    assign crs_next = pxy_reg - pyx_reg;

    assign x_ext = CW'(dot_reg);
    assign y_ext = CW'(crs_reg);

    always_comb
    begin
        x_next     = x_ext;
        y_next     = y_ext;
        z_next     = Z_0;
        fixed_next = 1'b0;
        if (dot_reg == '0 && crs_reg == '0)
        begin
            z_next     = Z_90;
            fixed_next = 1'b1;
        end
        else if (crs_reg == '0)
        begin
            z_next     = (dot_reg > 0) ? Z_0 : Z_180;
            fixed_next = 1'b1;
        end
        else if (dot_reg == '0)
        begin
            z_next     = (crs_reg > 0) ? Z_90 : Z_270;
            fixed_next = 1'b1;
        end
        else if (dot_reg < 0)
        begin
            if (crs_reg > 0)
            begin
                x_next = y_ext;
                y_next = -x_ext;
                z_next = Z_90;
            end
            else
            begin
                x_next = -y_ext;
                y_next = x_ext;
                z_next = -Z_90;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && probe.valid)
        begin
            fx_reg    <= probe.face_x;
            fy_reg    <= probe.face_y;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            side0_reg <= side0_next;
        end
        if (rdy1 && v0_reg)
        begin
            pxx_reg   <= pxx_next;
            pyy_reg   <= pyy_next;
            pxy_reg   <= pxy_next;
            pyx_reg   <= pyx_next;
            side1_reg <= side0_reg;
        end
        if (rdy2 && v1_reg)
        begin
            dot_reg   <= dot_next;
            crs_reg   <= crs_next;
            side2_reg <= side1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            side3_reg <= '{lo: side2_reg.lo, hi: side2_reg.hi, z_fixed: fixed_next};
        end
    end

    assign dn_valid = v3_reg;
    assign dn_x     = x_reg;
    assign dn_y     = y_reg;
    assign dn_z     = z_reg;
    assign dn_side  = side3_reg;

endmodule

`default_nettype wire

// File: rtl/ast_cordic_cell.sv
// ============================================================================
// ast_cordic_cell
// One vectoring CORDIC step with its own stage register.
// ============================================================================
`default_nettype none

module ast_cordic_cell import ast_pkg::*; #(
    parameter int COORD_BITS = 24,
    parameter int STEP       = 0
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         up_valid,
    output logic                              up_ready,
    input  wire logic signed [COORD_BITS+18:0] up_x,
    input  wire logic signed [COORD_BITS+18:0] up_y,
    input  wire logic signed [ZW-1:0]         up_z,
    input  wire side_t                        up_side,
    output logic                              dn_valid,
    input  wire logic                         dn_ready,
    output logic signed [COORD_BITS+18:0]     dn_x,
    output logic signed [COORD_BITS+18:0]     dn_y,
    output logic signed [ZW-1:0]              dn_z,
    output side_t                             dn_side
);

    localparam int CW = COORD_BITS + 19;
    localparam logic signed [ZW-1:0] ATAN_STEP = ZW'(ATAN_TAB[STEP]);

    logic                 valid_reg, valid_next, load;
    logic signed [CW-1:0] x_reg, y_reg, x_next, y_next, xs, ys;
    logic signed [ZW-1:0] z_reg, z_next;
    side_t                side_reg;

    assign load       = !valid_reg || dn_ready;
    assign up_ready   = load;
    assign valid_next = load ? up_valid : valid_reg;

    assign xs = up_x >>> STEP;
    assign ys = up_y >>> STEP;

    always_comb
    begin
        x_next = up_x;
        y_next = up_y;
        z_next = up_z;
        if (!up_side.z_fixed)
        begin
            if (up_y > 0)
            begin
                x_next = up_x + ys;
                y_next = up_y - xs;
                z_next = up_z + ATAN_STEP;
            end
            else
            begin
                x_next = up_x - ys;
                y_next = up_y + xs;
                z_next = up_z - ATAN_STEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= up_side;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_x     = x_reg;
    assign dn_y     = y_reg;
    assign dn_z     = z_reg;
    assign dn_side  = side_reg;

    a_x_positive: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !side_reg.z_fixed |-> x_reg > 0)
        else $error("cordic x not positive");

    a_fixed_axis: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && side_reg.z_fixed |->
            (z_reg == Z_0 || z_reg == Z_90 || z_reg == Z_180 || z_reg == Z_270))
        else $error("axis angle corrupted");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !dn_ready |=> valid_reg && $stable(z_reg) && $stable(x_reg))
        else $error("stage dropped word under stall");

endmodule

`default_nettype wire

// File: rtl/ast_back.sv
// ============================================================================
// ast_back
// Back stages: wrap to one turn, round, compare with the sector, output word.
// ============================================================================
`default_nettype none

module ast_back import ast_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire logic signed [ZW-1:0] up_z,
    input  wire side_t                up_side,
    ast_out_if.source                 verdict
);

    localparam int AW    = 9 + ANGLE_FRAC_BITS;
    localparam int CMPW  = AW + 1;
    localparam int SHIFT = ZFRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] HALF = ZW'(1 << (SHIFT - 1));
    localparam logic [AW-1:0]        FULL = AW'(360 << ANGLE_FRAC_BITS);

    logic                      v0_reg, v1_reg, v2_reg, v0_next, v1_next, v2_next;
    logic                      rdy0, rdy1, rdy2;

    logic signed [ZW-1:0]      zn, zr;
    logic [AW-1:0]             apre_reg, apre_next, a_reg, a_next;
    side_t                     side0_reg, side1_reg;

    logic signed [CMPW-1:0]    a_s, lf, hf;
    logic                      ins_next, ins_reg;
    logic [AW+ANGLE_OUT_W-1:0] a_wide;
    logic [ANGLE_OUT_W-1:0]    angle_next, angle_reg;

    assign rdy2     = !v2_reg || verdict.ready;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign up_ready = rdy0;

    assign v0_next = rdy0 ? up_valid : v0_reg;
    assign v1_next = rdy1 ? v0_reg : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;

    assign zn        = (up_z < 0) ? up_z + Z_360 : up_z;
    assign zr        = zn + HALF;
    assign apre_next = zr[SHIFT +: AW];

    assign a_next = (apre_reg >= FULL) ? apre_reg - FULL : apre_reg;

    assign a_s = signed'({1'b0, a_reg});
    assign lf  = CMPW'($signed(side1_reg.lo)) <<< ANGLE_FRAC_BITS;
    assign hf  = CMPW'($signed(side1_reg.hi)) <<< ANGLE_FRAC_BITS;

    always_comb
    begin
        if ($signed(side1_reg.lo) <= $signed(side1_reg.hi))
        begin
            ins_next = (a_s >= lf) && (a_s <= hf);
        end
        else
        begin
            ins_next = (a_s >= lf) || (a_s <= hf);
        end
    end

    assign a_wide     = {{ANGLE_OUT_W{1'b0}}, a_reg};
    assign angle_next = a_wide[ANGLE_OUT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && up_valid)
        begin
            apre_reg  <= apre_next;
            side0_reg <= up_side;
        end
        if (rdy1 && v0_reg)
        begin
            a_reg     <= a_next;
            side1_reg <= side0_reg;
        end
        if (rdy2 && v1_reg)
        begin
            ins_reg   <= ins_next;
            angle_reg <= angle_next;
        end
    end

    assign verdict.valid     = v2_reg;
    assign verdict.in_sector = ins_reg;
    assign verdict.angle_fx  = angle_reg;

endmodule

`default_nettype wire

// File: rtl/angular_sector_test.sv
// ============================================================================
// angular_sector_test
// Facing-relative target angle by pipelined CORDIC and sector containment.
// ============================================================================
// Pipeline from probe word accepted to verdict valid: 4 front stages, one
//   cell per CORDIC step, 3 back stages; each is a register with its own valid.
// Throughput: one word per cycle while the verdict is not stalled.
// A stalled verdict holds only the stages behind it that are full.
// Reset: asynchronous, clears the stage valid bits only; no state otherwise.
`default_nettype none

module angular_sector_test import ast_pkg::*; #(
    parameter int CORDIC_STEPS    = 16,
    parameter int COORD_BITS      = 24,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ast_in_if.sink    probe,
    ast_out_if.source verdict
);

    localparam int CW = COORD_BITS + 19;

    logic                 chain_valid [CORDIC_STEPS+1];
    logic                 chain_ready [CORDIC_STEPS+1];
    logic signed [CW-1:0] chain_x     [CORDIC_STEPS+1];
    logic signed [CW-1:0] chain_y     [CORDIC_STEPS+1];
    logic signed [ZW-1:0] chain_z     [CORDIC_STEPS+1];
    side_t                chain_side  [CORDIC_STEPS+1];

    ast_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .probe    (probe),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0]),
        .dn_x     (chain_x[0]),
        .dn_y     (chain_y[0]),
        .dn_z     (chain_z[0]),
        .dn_side  (chain_side[0])
    );

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cell
        ast_cordic_cell #(
            .COORD_BITS (COORD_BITS),
            .STEP       (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[k]),
            .up_ready (chain_ready[k]),
            .up_x     (chain_x[k]),
            .up_y     (chain_y[k]),
            .up_z     (chain_z[k]),
            .up_side  (chain_side[k]),
            .dn_valid (chain_valid[k+1]),
            .dn_ready (chain_ready[k+1]),
            .dn_x     (chain_x[k+1]),
            .dn_y     (chain_y[k+1]),
            .dn_z     (chain_z[k+1]),
            .dn_side  (chain_side[k+1])
        );
    end

    ast_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (chain_valid[CORDIC_STEPS]),
        .up_ready (chain_ready[CORDIC_STEPS]),
        .up_z     (chain_z[CORDIC_STEPS]),
        .up_side  (chain_side[CORDIC_STEPS]),
        .verdict  (verdict)
    );

endmodule

`default_nettype wire
